// File: hdl/uart_sensor_frame_receiver_defines.svh
// Assertion helpers for the frame receiver checker
`ifndef UART_SENSOR_FRAME_RECEIVER_DEFINES_SVH
`define UART_SENSOR_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define USFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame receiver check failed (same cycle)");

// next-cycle implication, disabled while in reset
`define USFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame receiver check failed (next cycle)");

`endif

// File: hdl/usfr_pkg.sv
package usfr_pkg;

    localparam int FRAME_STORED = 10;              // bytes 0..9 kept, byte 10 is the checksum
    localparam int COUNT_W      = 4;
    localparam int IDX_W        = $clog2(FRAME_STORED);
    localparam int OUT_DATA_W   = 88;

    localparam logic [7:0] HEADER_RESET = 8'hBB;
    localparam logic [7:0] IDLE_RESET   = 8'd10;

    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(FRAME_STORED);

    // register indexes (paddr[2])
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_IDLE   = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_CKERR = 1'b1;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] idle_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0] sensor_mean;
        logic [15:0] power_value;
        logic [7:0]  water_flag;
        logic [15:0] sensor_three;
        logic [15:0] sensor_two;
        logic [15:0] sensor_one;
    } readings_t;

    typedef struct packed {
        logic      frame_status;
        readings_t readings;
    } result_t;

endpackage

// File: hdl/uart_sensor_frame_receiver.sv
// A result beat appears on m_ the cycle after the beat carrying the checksum byte.
// One poll beat is accepted per cycle while s_tready is high; frame state is updated in the accepting cycle.
// s_tready drops only while a result is held and m_tready is low (single output register).
// Reset: aresetn synchronous, active low; clears count, sum, idle counter, held readings,
// output valid, and restores header 0xBB and idle limit 10. No clearing pass.
module uart_sensor_frame_receiver
    import usfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] byte_valid
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] sensor_one, [31:16] sensor_two, [47:32] sensor_three,
    // [55:48] water_flag, [71:56] power_value, [87:72] sensor_mean
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // [0] frame_status
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t    cfg;
    result_t result;
    logic    done;
    logic    in_fire;
    logic    space;

    assign s_tready = space;
    assign in_fire  = s_tvalid && s_tready;

    usfr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    usfr_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_fire    (in_fire),
        .byte_valid (s_tuser),
        .rx_byte    (s_tdata),
        .done       (done),
        .result     (result)
    );

    usfr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_fire && done),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/usfr_cfg_regs.sv
module usfr_cfg_regs
    import usfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_value <= HEADER_RESET;
            cfg_reg.idle_limit   <= IDLE_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_HEADER: cfg_reg.header_value <= pwdata[7:0];
                REG_IDLE:   cfg_reg.idle_limit   <= pwdata[7:0];
                default:    cfg_reg.header_value <= cfg_reg.header_value;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HEADER: prdata = {24'd0, cfg_reg.header_value};
            REG_IDLE:   prdata = {24'd0, cfg_reg.idle_limit};
            default:    prdata = 32'd0;
        endcase
    end

    // low address bits are a byte offset and ignored
    logic unused_addr;
    assign unused_addr = ^paddr[1:0];

    assign cfg = cfg_reg;

endmodule

// File: hdl/usfr_frame_core.sv
module usfr_frame_core
    import usfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       done,
    output result_t    result
);

    logic [7:0]         frame_bytes_reg [FRAME_STORED];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         ticks_reg, ticks_next;
    readings_t          held_reg, held_next;

    logic       store;
    logic       good;
    logic [8:0] ticks_inc;
    logic [7:0] byte0;
    logic [15:0] t1, t2;
    logic [16:0] t_sum;
    readings_t  fresh;

    assign store = byte_valid && (count_reg < COUNT_LAST);
    assign done  = byte_valid && !store;
    assign good  = (sum_reg == rx_byte);

    assign t1    = {frame_bytes_reg[1], frame_bytes_reg[2]};
    assign t2    = {frame_bytes_reg[3], frame_bytes_reg[4]};
    assign t_sum = {1'b0, t1} + {1'b0, t2};

    always_comb begin
        fresh.sensor_one   = t1;
        fresh.sensor_two   = t2;
        fresh.sensor_three = {frame_bytes_reg[5], frame_bytes_reg[6]};
        fresh.water_flag   = frame_bytes_reg[7];
        fresh.power_value  = {frame_bytes_reg[8], frame_bytes_reg[9]};
        fresh.sensor_mean  = t_sum[16:1];
    end

    // first byte as it stands after this beat is stored
    assign byte0 = (store && count_reg == '0) ? rx_byte : frame_bytes_reg[0];
    assign ticks_inc = (byte_valid ? 9'd0 : {1'b0, ticks_reg}) + 9'd1;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        held_next  = held_reg;
        if (store) begin
            count_next = count_reg + COUNT_W'(1);
            sum_next   = sum_reg + rx_byte;
        end else if (done) begin
            count_next = '0;
            sum_next   = '0;
            if (good) held_next = fresh;
        end

        if (ticks_inc > {1'b0, cfg.idle_limit}) begin
            ticks_next = '0;
            if (!done) begin
                count_next = '0;
                sum_next   = '0;
            end
        end else begin
            ticks_next = ticks_inc[7:0];
        end

        if (!done && count_next != '0 && byte0 != cfg.header_value) begin
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            ticks_reg <= '0;
            held_reg  <= '0;
        end else if (in_fire) begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ticks_reg <= ticks_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && store) frame_bytes_reg[count_reg[IDX_W-1:0]] <= rx_byte;
    end

    assign result.frame_status = good ? STATUS_OK : STATUS_CKERR;
    assign result.readings     = held_next;

endmodule

// File: hdl/usfr_out_stage.sv
module usfr_out_stage
    import usfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  result_t               result,
    output logic                  space,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    logic    valid_reg;
    result_t data_reg;

    // a beat can enter whenever the held result is gone or leaving
    assign space = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) data_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.readings;
    assign m_tuser  = data_reg.frame_status;

endmodule

// File: hdl/usfr_checker.sv
`include "uart_sensor_frame_receiver_defines.svh"

module usfr_checker
    import usfr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  pready
);

    logic [16:0] two_sum;
    assign two_sum = {1'b0, m_tdata[15:0]} + {1'b0, m_tdata[31:16]};

    // held result beat must not change under stall
    `USFR_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // input side never waits while the output register is empty
    `USFR_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    // mean field always tracks the first two temperatures
    `USFR_ASSERT_IMPLY(a_mean_consistent, aclk, aresetn, m_tvalid, m_tdata[87:72] == two_sum[16:1])
    `USFR_ASSERT_IMPLY(a_pready_high, aclk, aresetn, 1'b1, pready)

    logic unused_in;
    assign unused_in = s_tvalid;

endmodule

bind uart_sensor_frame_receiver usfr_checker u_usfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
